// File: design/gtog_pkg.sv
// Shared constants, codes and helper functions of the occupancy grid.
package gtog_pkg;

	localparam int FIELDS_MAX  = 4;
	localparam int DIM_MAX     = 16;
	localparam int GEN_LIMIT   = 32000;

	localparam int DIM_BITS    = $clog2(DIM_MAX);
	localparam int FIELD_BITS  = $clog2(FIELDS_MAX);
	localparam int ADDR_W      = FIELD_BITS + 3 * DIM_BITS;
	localparam int CELL_COUNT  = FIELDS_MAX * DIM_MAX * DIM_MAX * DIM_MAX;

	localparam int TAG_W       = 16;
	localparam int GEN_W       = 15;
	localparam int POS_W       = 13;
	localparam int RAD_W       = 12;
	localparam int FCNT_W      = 3;
	localparam int SIZE_W      = 5;
	localparam int SHIFT_W     = 3;
	localparam int CFG_W       = 12;
	localparam int CFG_IDX_W   = 3;
	localparam int FRAC_BITS   = 4;
	localparam int SIG_W       = RAD_W + (1 << SHIFT_W) - 1;
	localparam int COORD_W     = SIG_W + 3;

	// Command codes
	localparam logic [1:0] CMD_SET   = 2'd0;
	localparam logic [1:0] CMD_GET   = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SCALE   = 3'd5;

	// Size in use: zero acts as one, beyond the grid acts as the grid.
	function automatic logic [DIM_BITS:0] eff_size(input logic [SIZE_W-1:0] s);
		logic [DIM_BITS:0] r;
		begin
			if (s == '0)
				r = (DIM_BITS+1)'(1);
			else if (int'(s) > DIM_MAX)
				r = (DIM_BITS+1)'(DIM_MAX);
			else
				r = (DIM_BITS+1)'(s);
			return r;
		end
	endfunction

	// Floor of v / 2^(4+sh), negative to zero, capped at hi.
	function automatic logic [DIM_BITS:0] cell_floor(
		input logic signed [COORD_W-1:0] v,
		input logic [SHIFT_W-1:0]        sh,
		input logic [DIM_BITS:0]         hi
	);
		logic [COORD_W-1:0] m;
		logic [DIM_BITS:0]  r;
		begin
			m = $unsigned(v) >> (FRAC_BITS + int'(sh));
			if (v < 0)
				r = '0;
			else if (m > COORD_W'(hi))
				r = hi;
			else
				r = m[DIM_BITS:0];
			return r;
		end
	endfunction

endpackage

// File: design/generation_tagged_occupancy_grid_top.sv
// Generation-tagged 3D occupancy grid with one tag memory and a command sequencer.
//
// One item at a time: raise start with cmd and its fields while busy is low; the
// item is taken at that clock edge. A get answers with done high for exactly one
// cycle, occupied valid in that cycle; nothing can hold the answer off. A get
// runs through address, memory read and answer. A set registers its clamped box
// and then writes its cells, since the single write port of the tag memory
// stores one cell per cycle. A dropped set, an unused command and a clear that
// stays within the generation limit leave busy low. A clear past the limit
// sweeps the tag memory at one entry per cycle with busy high. After reset the
// same clearing pass runs, busy high until it ends, before the first item is
// taken. Configuration writes are taken at any time and should come while idle.
module generation_tagged_occupancy_grid_top
	import gtog_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 cmd,
	input  logic [2:0]                 field_index,
	input  logic signed [POS_W-1:0]    pos_x,
	input  logic signed [POS_W-1:0]    pos_y,
	input  logic signed [POS_W-1:0]    pos_z,
	input  logic [RAD_W-1:0]           radius,
	output logic                       done,
	output logic                       occupied,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PREP   = 3'd1;
	localparam logic [2:0] ST_BOX    = 3'd2;
	localparam logic [2:0] ST_WRITE  = 3'd3;
	localparam logic [2:0] ST_LOOKUP = 3'd4;
	localparam logic [2:0] ST_RESP   = 3'd5;
	localparam logic [2:0] ST_WIPE   = 3'd6;

	// Configuration registers
	logic [FCNT_W-1:0]  field_count_q;
	logic [SIZE_W-1:0]  size_q [3];
	logic [SHIFT_W-1:0] shift_q;
	logic [RAD_W-1:0]   min_scale_q;

	// Control
	logic [2:0]         state_q;
	logic [GEN_W-1:0]   gen_q;
	logic [ADDR_W-1:0]  wipe_q;
	logic               force_q;

	// Item registers
	logic [FIELD_BITS-1:0]    field_q;
	logic signed [POS_W-1:0]  pos_q [3];
	logic [RAD_W-1:0]         radius_q;
	logic [SIG_W-1:0]         sig_q;
	logic [DIM_BITS-1:0]      lo_q  [3];
	logic [DIM_BITS:0]        hi_q  [3];
	logic [DIM_BITS-1:0]      cur_q [3];

	// Tag memory
	logic [TAG_W-1:0]   tag_mem [CELL_COUNT];
	logic [TAG_W-1:0]   rdata_q;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [TAG_W-1:0]   mem_wdata;
	logic [ADDR_W-1:0]  mem_raddr;

	logic [DIM_BITS:0]   size_eff [3];
	logic [FCNT_W-1:0]   count_eff;
	logic                field_ok;
	logic                accept;
	logic [SIG_W-1:0]    min_sig;
	logic [DIM_BITS:0]   lo_c  [3];
	logic [DIM_BITS:0]   hi_c  [3];
	logic [DIM_BITS-1:0] get_c [3];
	logic [2:0]          last;
	logic [TAG_W-1:0]    tag_next;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign count_eff = (int'(field_count_q) > FIELDS_MAX) ? FCNT_W'(FIELDS_MAX)
	                                                      : field_count_q;
	assign field_ok  = (field_index < count_eff);
	assign tag_next  = {1'b0, gen_q} + TAG_W'(1);
	assign min_sig   = SIG_W'(min_scale_q) << shift_q;

	// Box bounds and lookup cell, one axis per lane
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			size_eff[a] = eff_size(size_q[a]);
			lo_c[a] = cell_floor(COORD_W'(pos_q[a]) - $signed(COORD_W'(sig_q)), shift_q,
			                     size_eff[a] - (DIM_BITS+1)'(1));
			hi_c[a] = cell_floor(COORD_W'(pos_q[a]) + $signed(COORD_W'(sig_q)), shift_q,
			                     size_eff[a]);
			if (hi_c[a] < lo_c[a] + (DIM_BITS+1)'(1))
				hi_c[a] = lo_c[a] + (DIM_BITS+1)'(1);
			get_c[a] = DIM_BITS'(cell_floor(COORD_W'(pos_q[a]), shift_q,
			                                size_eff[a] - (DIM_BITS+1)'(1)));
			last[a] = ({1'b0, cur_q[a]} + (DIM_BITS+1)'(1)) == hi_q[a];
		end
	end

	// Memory port selection
	always_comb begin
		mem_we    = (state_q == ST_WRITE) || (state_q == ST_WIPE);
		mem_waddr = (state_q == ST_WIPE) ? wipe_q
		                                 : {field_q, cur_q[0], cur_q[1], cur_q[2]};
		mem_wdata = (state_q == ST_WIPE) ? '0 : tag_next;
		mem_raddr = {field_q, get_c[0], get_c[1], get_c[2]};
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			tag_mem[mem_waddr] <= mem_wdata;
		rdata_q <= tag_mem[mem_raddr];
	end

	// Answer: out-of-range field reads as occupied
	assign done     = (state_q == ST_RESP);
	assign occupied = force_q || (rdata_q > {1'b0, gen_q});

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_count_q <= FCNT_W'(4);
			size_q[0]     <= SIZE_W'(16);
			size_q[1]     <= SIZE_W'(16);
			size_q[2]     <= SIZE_W'(16);
			shift_q       <= '0;
			min_scale_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FIELD_COUNT: field_count_q <= cfg_data[FCNT_W-1:0];
				REG_SIZE_X:      size_q[0]     <= cfg_data[SIZE_W-1:0];
				REG_SIZE_Y:      size_q[1]     <= cfg_data[SIZE_W-1:0];
				REG_SIZE_Z:      size_q[2]     <= cfg_data[SIZE_W-1:0];
				REG_SHIFT:       shift_q       <= cfg_data[SHIFT_W-1:0];
				REG_MIN_SCALE:   min_scale_q   <= cfg_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	// Item payload capture and box registers
	always_ff @(posedge clk) begin
		if (accept) begin
			field_q  <= field_index[FIELD_BITS-1:0];
			pos_q[0] <= pos_x;
			pos_q[1] <= pos_y;
			pos_q[2] <= pos_z;
			radius_q <= radius;
			sig_q    <= SIG_W'(0);
		end
		// Raise sigma to the minimum only when scaling is on
		if (state_q == ST_PREP) begin
			if ((shift_q != '0) && (SIG_W'(radius_q) < min_sig))
				sig_q <= min_sig;
			else
				sig_q <= SIG_W'(radius_q);
		end
		if (state_q == ST_BOX) begin
			for (int a = 0; a < 3; a++) begin
				lo_q[a]  <= lo_c[a][DIM_BITS-1:0];
				hi_q[a]  <= hi_c[a];
				cur_q[a] <= lo_c[a][DIM_BITS-1:0];
			end
		end
		// Advance z fastest, then y, then x
		if (state_q == ST_WRITE) begin
			if (last[2]) begin
				cur_q[2] <= lo_q[2];
				if (last[1]) begin
					cur_q[1] <= lo_q[1];
					cur_q[0] <= cur_q[0] + DIM_BITS'(1);
				end else begin
					cur_q[1] <= cur_q[1] + DIM_BITS'(1);
				end
			end else begin
				cur_q[2] <= cur_q[2] + DIM_BITS'(1);
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WIPE;
			gen_q   <= '0;
			wipe_q  <= '0;
			force_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (cmd)
							CMD_SET: begin
								if (field_ok)
									state_q <= ST_PREP;
							end
							CMD_GET: begin
								// Same timing for every get; a bad field forces the answer
								force_q <= !field_ok;
								state_q <= ST_LOOKUP;
							end
							CMD_CLEAR: begin
								// At or past the limit: restart at zero and sweep the store
								if (int'(gen_q) >= GEN_LIMIT) begin
									gen_q   <= '0;
									state_q <= ST_WIPE;
								end else begin
									gen_q <= gen_q + GEN_W'(1);
								end
							end
							default: ;
						endcase
					end
				end
				ST_PREP:   state_q <= ST_BOX;
				ST_BOX:    state_q <= ST_WRITE;
				ST_WRITE: begin
					if (last[0] && last[1] && last[2])
						state_q <= ST_IDLE;
				end
				ST_LOOKUP: state_q <= ST_RESP;
				ST_RESP: begin
					force_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				ST_WIPE: begin
					wipe_q <= wipe_q + ADDR_W'(1);
					if (wipe_q == {ADDR_W{1'b1}})
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: design/gtog_checker.sv
// Port-level checks of the occupancy grid and their bind to the top level.
module gtog_checker
	import gtog_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] cmd,
	input logic       done
);

	// An answer only comes while the block is occupied with its get
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done without busy");

	// Every accepted get answers once it has passed through the lookup state
	a_get_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == CMD_GET) |=> ##1 done)
		else $error("get did not answer");

	// The answer strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// A set never answers
	a_set_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == CMD_SET) |=> !done)
		else $error("set produced an answer");

	// Leaving reset starts the clearing pass
	a_reset_wipe: assert property (@(posedge clk)
		$rose(arst_n) |-> busy)
		else $error("no clearing pass after reset");

endmodule

bind generation_tagged_occupancy_grid_top gtog_checker u_gtog_checker (.*);
